// ===== rtl/ptmg_pkg.sv =====
// Shared types, register codes and constants of the tone map and gamma block.
// The exponent constants come from an integer square root chain at elaboration.
// Depends on nothing.
package ptmg_pkg;

	localparam int IN_W   = 24;
	localparam int CW     = 25;
	localparam int OUT_W  = 8;
	localparam int IG_W   = 14;
	localparam int IDX_W  = 2;
	localparam int EXP_ST = 16;

	localparam logic [IG_W-1:0] GAMMA_ONE = 14'd4096;

	typedef enum logic [IDX_W-1:0] {
		REG_SHOW = 2'd0,
		REG_IGAM = 2'd1
	} ptmg_reg_t;

	typedef struct packed {
		logic            show;
		logic [IG_W-1:0] igam;
	} ptmg_cfg_t;

	function automatic logic [63:0] isqrt64(logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] bt;
		v  = v_in;
		r  = '0;
		bt = 64'h4000_0000_0000_0000;
		for (int j = 0; j < 32; j++)
			if (bt > v) bt = bt >> 2;
		for (int j = 0; j < 32; j++) begin
			if (bt != 64'd0) begin
				if (v >= r + bt) begin
					v = v - (r + bt);
					r = (r >> 1) + bt;
				end else begin
					r = r >> 1;
				end
				bt = bt >> 2;
			end
		end
		return r;
	endfunction

	// 2^(-2^-i) in Q0.32
	function automatic logic [31:0] k_const(int i);
		logic [63:0] k;
		k = 64'h8000_0000;
		for (int j = 0; j < EXP_ST; j++)
			if (j < i) k = isqrt64(k << 32);
		return k[31:0];
	endfunction

endpackage

// ===== rtl/pixel_tone_map_gamma.sv =====
// Tone map and gamma correction of one RGB pixel per clock.
// Pipeline stages: one select stage, FRAC_BITS+1 divider stages,
// 35 power stages (16 log squarings, 16 exponent multiplies) and one scale stage.
// Throughput one pixel per cycle; the whole pipeline holds while the output stalls.
// Reset clears the valid pipeline, turns red marking of overbright pixels off and
// sets inverse_gamma to 4096. Depends on ptmg_pkg and ptmg_lane.
module pixel_tone_map_gamma #(
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [71:0]                 s_tdata,   // red_in, green_in, blue_in
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [23:0]                 m_tdata,   // red_out, green_out, blue_out
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ptmg_pkg::IDX_W-1:0]  cfg_index,
	input  logic [ptmg_pkg::IG_W-1:0]   cfg_data
);
	import ptmg_pkg::*;

	localparam int LAT = FRAC_BITS + 38;
	localparam logic [CW-1:0] ONE = CW'(1) << FRAC_BITS;

	ptmg_cfg_t cfg_q;
	logic [LAT-1:0] vld_q;
	logic en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.show <= 1'b0;
			cfg_q.igam <= GAMMA_ONE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SHOW: cfg_q.show <= cfg_data[0];
				REG_IGAM: cfg_q.igam <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en       = !vld_q[LAT-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[LAT-2:0], s_tvalid};
	end

	logic [CW-1:0]   ci [3];
	logic [CW-1:0]   cs [3];
	logic [IN_W-1:0] mx;
	logic            over;
	logic            nd;

	logic [CW-1:0]   c_s1 [3];
	logic [IN_W-1:0] m_s1;
	logic            nd_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ci[i] = {1'b0, s_tdata[i*IN_W +: IN_W]};
			cs[i] = ci[i];
		end
		mx = s_tdata[IN_W-1:0];
		if (s_tdata[2*IN_W-1:IN_W] > mx) mx = s_tdata[2*IN_W-1:IN_W];
		if (s_tdata[3*IN_W-1:2*IN_W] > mx) mx = s_tdata[3*IN_W-1:2*IN_W];
		over = (ci[0] > ONE) || (ci[1] > ONE) || (ci[2] > ONE);
		nd   = 1'b0;
		if (cfg_q.show) begin
			if (over) begin
				cs[0] = ONE;
				cs[1] = '0;
				cs[2] = '0;
			end
		end else begin
			nd = {1'b0, mx} > ONE;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) c_s1[i] <= cs[i];
			m_s1  <= mx;
			nd_s1 <= nd;
		end
	end

	logic [OUT_W-1:0] lo [3];

	for (genvar i = 0; i < 3; i++) begin : g_lane
		ptmg_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk (clk),
			.en  (en),
			.c   (c_s1[i]),
			.m   (m_s1),
			.nd  (nd_s1),
			.p   (cfg_q.igam),
			.o   (lo[i])
		);
	end

	assign m_tdata = {lo[2], lo[1], lo[0]};

endmodule

// ===== rtl/ptmg_pow.sv =====
// Pipelined power unit: x^p through a 16 stage log2 squaring chain and a
// 16 stage exponent multiplier chain, with zero, unity and bypass handling.
// Depends on ptmg_pkg.
module ptmg_pow #(
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [FRAC_BITS:0]          x,
	input  logic [ptmg_pkg::IG_W-1:0]   p,
	output logic [FRAC_BITS:0]          res
);
	import ptmg_pkg::*;

	localparam int VW = FRAC_BITS + 1;
	localparam int SW = VW + 3;
	localparam logic [VW-1:0] ONE = VW'(1) << FRAC_BITS;

	logic [4:0]    b;
	logic [31:0]   y0;
	logic [SW-1:0] side_a;
	logic [4:0]    lb_a;
	logic [31:0]   y_a;

	logic [31:0]   sq_y_s  [EXP_ST];
	logic [15:0]   sq_f_s  [EXP_ST];
	logic [4:0]    sq_lb_s [EXP_ST];
	logic [SW-1:0] sq_sd_s [EXP_ST];

	logic [22:0]   e_s;
	logic [SW-1:0] e_sd_s;

	logic [32:0]   ex_r_s  [EXP_ST];
	logic [22:0]   ex_e_s  [EXP_ST];
	logic [SW-1:0] ex_sd_s [EXP_ST];

	logic [VW-1:0] res_q;

	// side = {bypass, special, special_is_one, x}
	always_comb begin
		b = '0;
		for (int i = 0; i < VW - 1; i++)
			if (x[i]) b = 5'(i);
		y0 = 32'(x) << (5'd30 - b);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_a    <= y0;
			lb_a   <= 5'(FRAC_BITS) - b;
			side_a <= {p == GAMMA_ONE, (x == '0) || (x >= ONE),
				(x == '0) ? (p == '0) : 1'b1, x};
		end
	end

	for (genvar k = 0; k < EXP_ST; k++) begin : g_sq
		logic [31:0]   yi;
		logic [15:0]   fi;
		logic [4:0]    lbi;
		logic [SW-1:0] sdi;
		logic [61:0]   sq;
		logic [31:0]   t;
		if (k == 0) begin : g_first
			assign yi  = y_a;
			assign fi  = '0;
			assign lbi = lb_a;
			assign sdi = side_a;
		end else begin : g_next
			assign yi  = sq_y_s[k-1];
			assign fi  = sq_f_s[k-1];
			assign lbi = sq_lb_s[k-1];
			assign sdi = sq_sd_s[k-1];
		end
		assign sq = yi[30:0] * yi[30:0];
		assign t  = sq[61:30];
		always_ff @(posedge clk) begin
			if (en) begin
				sq_y_s[k]  <= t[31] ? (t >> 1) : t;
				sq_f_s[k]  <= {fi[14:0], t[31]};
				sq_lb_s[k] <= lbi;
				sq_sd_s[k] <= sdi;
			end
		end
	end

	logic [20:0] lg;
	logic [34:0] lp;
	assign lg = {sq_lb_s[EXP_ST-1], 16'd0} - {5'd0, sq_f_s[EXP_ST-1]};
	assign lp = lg * p;

	always_ff @(posedge clk) begin
		if (en) begin
			e_s    <= lp[34:12];
			e_sd_s <= sq_sd_s[EXP_ST-1];
		end
	end

	for (genvar k = 0; k < EXP_ST; k++) begin : g_ex
		localparam logic [31:0] KI = k_const(k + 1);
		logic [32:0]   ri;
		logic [22:0]   ei;
		logic [SW-1:0] sdi;
		logic [64:0]   pr;
		if (k == 0) begin : g_first
			assign ri  = 33'h1_0000_0000;
			assign ei  = e_s;
			assign sdi = e_sd_s;
		end else begin : g_next
			assign ri  = ex_r_s[k-1];
			assign ei  = ex_e_s[k-1];
			assign sdi = ex_sd_s[k-1];
		end
		assign pr = ri * KI;
		always_ff @(posedge clk) begin
			if (en) begin
				ex_r_s[k]  <= ei[15-k] ? pr[64:32] : ri;
				ex_e_s[k]  <= ei;
				ex_sd_s[k] <= sdi;
			end
		end
	end

	logic [32:0]   rs;
	logic [32:0]   rv;
	logic [VW-1:0] rc;
	logic [SW-1:0] sdf;
	logic [6:0]    nf;
	logic [VW-1:0] xf;

	always_comb begin
		sdf = ex_sd_s[EXP_ST-1];
		nf  = ex_e_s[EXP_ST-1][22:16];
		xf  = sdf[VW-1:0];
		rs  = (nf > 7'd32) ? '0 : (ex_r_s[EXP_ST-1] >> nf);
		rv  = rs >> (32 - FRAC_BITS);
		rc  = (rv > 33'(ONE)) ? ONE : rv[VW-1:0];
		if (sdf[SW-1])
			rc = (xf > ONE) ? ONE : xf;
		else if (sdf[SW-2])
			rc = sdf[SW-3] ? ONE : '0;
	end

	always_ff @(posedge clk) begin
		if (en) res_q <= rc;
	end

	assign res = res_q;

endmodule

// ===== rtl/ptmg_lane.sv =====
// One color lane: restoring divider one quotient bit a stage, power unit,
// then the scale to an 8 bit display level.
// Depends on ptmg_pkg and ptmg_pow.
module ptmg_lane #(
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [ptmg_pkg::CW-1:0]     c,
	input  logic [ptmg_pkg::IN_W-1:0]   m,
	input  logic                        nd,
	input  logic [ptmg_pkg::IG_W-1:0]   p,
	output logic [ptmg_pkg::OUT_W-1:0]  o
);
	import ptmg_pkg::*;

	localparam int VW  = FRAC_BITS + 1;
	localparam int DST = FRAC_BITS + 1;

	logic [IN_W-1:0] div_rem_s [DST];
	logic [VW-1:0]   div_q_s   [DST];
	logic [CW-1:0]   div_c_s   [DST];
	logic [IN_W-1:0] div_m_s   [DST];
	logic            div_nd_s  [DST];

	for (genvar j = 0; j < DST; j++) begin : g_div
		logic [CW-1:0]   rin;
		logic [VW-1:0]   qi;
		logic [CW-1:0]   ci;
		logic [IN_W-1:0] mi;
		logic            ndi;
		logic            qb;
		logic [CW-1:0]   rout;
		if (j == 0) begin : g_first
			assign rin = c;
			assign qi  = '0;
			assign ci  = c;
			assign mi  = m;
			assign ndi = nd;
		end else begin : g_next
			assign rin = {div_rem_s[j-1], 1'b0};
			assign qi  = div_q_s[j-1];
			assign ci  = div_c_s[j-1];
			assign mi  = div_m_s[j-1];
			assign ndi = div_nd_s[j-1];
		end
		assign qb   = rin >= {1'b0, mi};
		assign rout = qb ? (rin - {1'b0, mi}) : rin;
		always_ff @(posedge clk) begin
			if (en) begin
				div_rem_s[j] <= rout[IN_W-1:0];
				div_q_s[j]   <= {qi[VW-2:0], qb};
				div_c_s[j]   <= ci;
				div_m_s[j]   <= mi;
				div_nd_s[j]  <= ndi;
			end
		end
	end

	logic [VW-1:0] xv;
	logic [VW-1:0] pv;
	logic [VW+7:0] sc;
	logic [OUT_W-1:0] o_q;

	assign xv = div_nd_s[DST-1] ? div_q_s[DST-1] : div_c_s[DST-1][VW-1:0];

	ptmg_pow #(.FRAC_BITS(FRAC_BITS)) u_pow (
		.clk (clk),
		.en  (en),
		.x   (xv),
		.p   (p),
		.res (pv)
	);

	assign sc = pv * 8'd255;

	always_ff @(posedge clk) begin
		if (en) o_q <= sc[FRAC_BITS +: OUT_W];
	end

	assign o = o_q;

endmodule
